// ----- rtl/fqa_pkg.sv -----
package fqa_pkg;

   localparam int WORD_W = 32;
   localparam int FRAC_W = 8;
   localparam int STEPS_PER_STG = 4;
   localparam int NUM_W = WORD_W + FRAC_W;
   localparam int NDIV = (NUM_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
   localparam int DIVN_W = NDIV * STEPS_PER_STG;
   localparam int PROD_W = 2 * WORD_W;
   localparam int SAT_W = 2 * WORD_W + FRAC_W + 1;

   localparam logic [WORD_W-1:0] MAX_W = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] MIN_W = {1'b1, {(WORD_W-1){1'b0}}};
   localparam logic [SAT_W-1:0] LIM_NEG = SAT_W'(1) << (WORD_W - 1);
   localparam logic [SAT_W-1:0] LIM_POS = LIM_NEG - SAT_W'(1);
   localparam logic [SAT_W-1:0] HALF = SAT_W'(1) << (FRAC_W - 1);

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
      OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TOINT, OP_FROMINT
   } op_type;

   typedef struct packed {
      logic [WORD_W-1:0] res;
      logic              ovf;
   } sat_type;

   typedef struct packed {
      logic [WORD_W-1:0] rem;
      logic [DIVN_W-1:0] num;
      logic [DIVN_W-1:0] quo;
   } div_type;

   typedef struct packed {
      op_type            kind;
      logic              na;
      logic              neg;
      logic [WORD_W-1:0] ma;
      logic [WORD_W-1:0] mb;
      logic [WORD_W-1:0] sres;
      logic              scmp;
      logic              sovf;
      logic [PROD_W-1:0] prod;
      logic [WORD_W-1:0] mres;
      logic              movf;
   } pipe_type;

   // Clamp an unsigned magnitude with a sign into the signed word range.
   function automatic sat_type sat_mag(logic neg, logic [SAT_W-1:0] mag);
      sat_type s;
      logic [SAT_W-1:0] lim;
      lim = neg ? LIM_NEG : LIM_POS;
      if (mag > lim) begin
         s.ovf = 1'b1;
         s.res = neg ? MIN_W : MAX_W;
      end else begin
         s.ovf = 1'b0;
         s.res = neg ? (~mag[WORD_W-1:0] + WORD_W'(1)) : mag[WORD_W-1:0];
      end
      return s;
   endfunction

endpackage

// ----- rtl/fqa_simple_ops.sv -----
module fqa_simple_ops import fqa_pkg::*; (
   input  op_type            kind,
   input  logic [WORD_W-1:0] a,
   input  logic [WORD_W-1:0] b,
   output logic [WORD_W-1:0] res,
   output logic              cmp,
   output logic              ovf
);

   logic signed [WORD_W-1:0] sa;
   logic signed [WORD_W-1:0] sb;
   logic [WORD_W:0] sum;
   logic [WORD_W:0] dif;
   logic lt_ab;
   logic lt_ba;
   logic signed [WORD_W-1:0] fi_hi;
   logic signed [WORD_W-1:0] fi_lo;

   assign sa = a;
   assign sb = b;
   assign sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
   assign dif = {a[WORD_W-1], a} - {b[WORD_W-1], b};
   assign lt_ab = sa < sb;
   assign lt_ba = sb < sa;
   assign fi_hi = $signed(MAX_W) >>> FRAC_W;
   assign fi_lo = $signed(MIN_W) >>> FRAC_W;

   always_comb begin
      res = '0;
      cmp = 1'b0;
      ovf = 1'b0;
      case (kind)
         OP_ADD: begin
            ovf = sum[WORD_W] != sum[WORD_W-1];
            res = ovf ? (a[WORD_W-1] ? MIN_W : MAX_W) : sum[WORD_W-1:0];
         end
         OP_SUB: begin
            ovf = dif[WORD_W] != dif[WORD_W-1];
            res = ovf ? (a[WORD_W-1] ? MIN_W : MAX_W) : dif[WORD_W-1:0];
         end
         OP_GT: cmp = lt_ba;
         OP_LT: cmp = lt_ab;
         OP_GE: cmp = !lt_ab;
         OP_LE: cmp = !lt_ba;
         OP_EQ: cmp = a == b;
         OP_NE: cmp = a != b;
         OP_MIN: res = lt_ab ? a : b;
         OP_MAX: res = lt_ba ? a : b;
         OP_INC: begin
            ovf = a == MAX_W;
            res = ovf ? MAX_W : a + WORD_W'(1);
         end
         OP_DEC: begin
            ovf = a == MIN_W;
            res = ovf ? MIN_W : a - WORD_W'(1);
         end
         OP_TOINT: res = sa >>> FRAC_W;
         OP_FROMINT: begin
            if (sa > fi_hi) begin
               ovf = 1'b1;
               res = MAX_W;
            end else if (sa < fi_lo) begin
               ovf = 1'b1;
               res = MIN_W;
            end else begin
               res = a << FRAC_W;
            end
         end
         default: res = '0;
      endcase
   end

endmodule

// ----- rtl/fqa_div_stage.sv -----
module fqa_div_stage import fqa_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  div_type           d_in,
   input  logic [WORD_W-1:0] divisor,
   output div_type           d_ff
);

   div_type d_in_nx;

   // A group of restoring division steps, one quotient bit each.
   always_comb begin
      logic [WORD_W-1:0] r;
      logic [DIVN_W-1:0] n;
      logic [DIVN_W-1:0] q;
      logic [WORD_W:0]   t;
      r = d_in.rem;
      n = d_in.num;
      q = d_in.quo;
      for (int k = 0; k < STEPS_PER_STG; k++) begin
         t = {r, n[DIVN_W-1]};
         n = n << 1;
         if (t >= {1'b0, divisor}) begin
            t = t - {1'b0, divisor};
            q = {q[DIVN_W-2:0], 1'b1};
         end else begin
            q = {q[DIVN_W-2:0], 1'b0};
         end
         r = t[WORD_W-1:0];
      end
      d_in_nx.rem = r;
      d_in_nx.num = n;
      d_in_nx.quo = q;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_nx;
      end
   end

endmodule

// ----- rtl/fixed_point_q24_8_alu.sv -----
// Signed Q24.8 fixed-point ALU with a fixed-latency pipeline.
// Every opcode takes the same path, from the input register through the divider
// stages to the result register; the divider sets the depth.
// Throughput: one transfer per cycle; the whole pipeline holds when the
// result register is full and rsp_ready is low.
// Reset is synchronous and active high and clears only the valid bits.
module fixed_point_q24_8_alu import fqa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_kind,
   input  logic [WORD_W-1:0] req_operand_a,
   input  logic [WORD_W-1:0] req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [WORD_W-1:0] rsp_result_value,
   output logic              rsp_compare_flag,
   output logic              rsp_overflow_flag,
   output logic              rsp_divide_by_zero
);

   // One global enable: every stage moves when the result register can take
   // a new word, so no transfer is dropped or repeated during a stall.
   logic en;

   logic     vld_ff [NDIV+1];
   pipe_type p_ff   [NDIV+1];
   pipe_type p_in   [NDIV+1];
   div_type  d_ff   [NDIV+1];
   div_type  d0_in;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] res_ff, res_in;
   logic              cmp_ff, cmp_in;
   logic              ovf_ff, ovf_in;
   logic              dz_ff, dz_in;

   logic [WORD_W-1:0] s_res;
   logic              s_cmp;
   logic              s_ovf;

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   fqa_simple_ops u_simple (
      .kind (op_type'(req_kind)),
      .a    (req_operand_a),
      .b    (req_operand_b),
      .res  (s_res),
      .cmp  (s_cmp),
      .ovf  (s_ovf)
   );

   // Stage one: operand magnitudes, the combinational simple operations and the
   // divider's starting numerator.
   always_comb begin
      logic nb;
      p_in[0].kind = op_type'(req_kind);
      p_in[0].na = req_operand_a[WORD_W-1];
      nb = req_operand_b[WORD_W-1];
      p_in[0].neg = p_in[0].na ^ nb;
      p_in[0].ma = p_in[0].na ? (~req_operand_a + WORD_W'(1)) : req_operand_a;
      p_in[0].mb = nb ? (~req_operand_b + WORD_W'(1)) : req_operand_b;
      p_in[0].sres = s_res;
      p_in[0].scmp = s_cmp;
      p_in[0].sovf = s_ovf;
      p_in[0].prod = '0;
      p_in[0].mres = '0;
      p_in[0].movf = 1'b0;
      d0_in.rem = '0;
      d0_in.num = DIVN_W'(p_in[0].ma) << FRAC_W;
      d0_in.quo = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= p_in[0];
         d_ff[0] <= d0_in;
      end
   end

   // Divider stages. The multiplier rides alongside: the product is formed in
   // the first of them and rounded and clamped in the second.
   for (genvar i = 0; i < NDIV; i++) begin : g_stage
      fqa_div_stage u_div (
         .clock   (clock),
         .en      (en),
         .d_in    (d_ff[i]),
         .divisor (p_ff[i].mb),
         .d_ff    (d_ff[i+1])
      );

      always_comb begin
         logic [SAT_W-1:0] pr;
         sat_type ms;
         p_in[i+1] = p_ff[i];
         pr = '0;
         ms = '0;
         if (i == 0) begin
            p_in[i+1].prod = PROD_W'(p_ff[i].ma) * PROD_W'(p_ff[i].mb);
         end else if (i == 1) begin
            pr = SAT_W'(p_ff[i].prod) + HALF;
            ms = sat_mag(p_ff[i].neg, pr >> FRAC_W);
            p_in[i+1].mres = ms.res;
            p_in[i+1].movf = ms.ovf;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[i+1] <= p_in[i+1];
         end
      end
   end

   // Last stage: round the quotient to nearest (ties away from zero), clamp,
   // and pick the result for the opcode.
   always_comb begin
      pipe_type pl;
      div_type dv;
      logic rnd;
      logic [SAT_W-1:0] q1;
      sat_type ds;
      pl = p_ff[NDIV];
      dv = d_ff[NDIV];
      rnd = {dv.rem, 1'b0} >= {1'b0, pl.mb};
      q1 = SAT_W'(dv.quo) + SAT_W'(rnd);
      ds = sat_mag(pl.neg, q1);
      res_in = pl.sres;
      cmp_in = pl.scmp;
      ovf_in = pl.sovf;
      dz_in = 1'b0;
      case (pl.kind)
         OP_MUL: begin
            res_in = pl.mres;
            ovf_in = pl.movf;
         end
         OP_DIV: begin
            if (pl.mb == '0) begin
               dz_in = 1'b1;
               ovf_in = 1'b1;
               res_in = pl.na ? MIN_W : MAX_W;
            end else begin
               res_in = ds.res;
               ovf_in = ds.ovf;
            end
         end
         default: dz_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         cmp_ff <= cmp_in;
         ovf_ff <= ovf_in;
         dz_ff <= dz_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_value = res_ff;
   assign rsp_compare_flag = cmp_ff;
   assign rsp_overflow_flag = ovf_ff;
   assign rsp_divide_by_zero = dz_ff;

`ifndef SYNTHESIS
   // A zero divisor always saturates.
   a_dz_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_overflow_flag)
      else $error("divide by zero without overflow");

   a_dz_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         (rsp_result_value == MAX_W || rsp_result_value == MIN_W))
      else $error("divide by zero result not at a limit");

   // Comparisons return only the flag.
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_flag |-> rsp_result_value == '0 && !rsp_overflow_flag)
      else $error("comparison with nonzero result");

   // A stalled result must not be replaced by the stage behind it.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(res_ff) && rsp_valid_ff)
      else $error("result register changed while stalled");
`endif

endmodule

// ----- bench/fixed_point_q24_8_alu_checker.sv -----
module fixed_point_q24_8_alu_checker import fqa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [3:0]        req_kind,
   input  logic [WORD_W-1:0] req_operand_a,
   input  logic [WORD_W-1:0] req_operand_b,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [WORD_W-1:0] rsp_result_value,
   input  logic              rsp_compare_flag,
   input  logic              rsp_overflow_flag,
   input  logic              rsp_divide_by_zero,
   output int                error_count,
   output int                pending_count,
   output int                result_count
);

   typedef struct {
      logic [31:0] value;
      logic        cmp;
      logic        ovf;
      logic        dz;
   } alu_result_t;

   alu_result_t expected_results[$];

   // Clamp a signed wide value into the 32-bit word range.
   function automatic void clamp_word(input logic signed [127:0] v,
                                      inout alu_result_t r);
      if (v > 128'sd2147483647) begin
         r.value = 32'h7fff_ffff;
         r.ovf = 1'b1;
      end else if (v < -128'sd2147483648) begin
         r.value = 32'h8000_0000;
         r.ovf = 1'b1;
      end else begin
         r.value = v[31:0];
      end
   endfunction

   // Round a magnitude quotient num/den to nearest, ties away from zero.
   function automatic logic [127:0] round_div(input logic [127:0] num,
                                              input logic [127:0] den);
      logic [127:0] q;
      logic [127:0] rm;
      q = num / den;
      rm = num % den;
      if (rm >= den - rm) q = q + 1;
      return q;
   endfunction

   function automatic alu_result_t compute_alu(input op_type op,
                                               input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      alu_result_t r;
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic [127:0] ma;
      logic [127:0] mb;
      logic [127:0] mag;
      logic neg;
      r = '{32'd0, 1'b0, 1'b0, 1'b0};
      wa = a;
      wb = b;
      ma = (wa < 0) ? -wa : wa;
      mb = (wb < 0) ? -wb : wb;
      neg = (a < 0) != (b < 0);
      case (op)
         OP_ADD:     clamp_word(wa + wb, r);
         OP_SUB:     clamp_word(wa - wb, r);
         OP_MUL: begin
            mag = round_div(ma * mb, 128'd256);
            clamp_word(neg ? -$signed(mag) : $signed(mag), r);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.dz = 1'b1;
               r.ovf = 1'b1;
               r.value = (a < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            end else begin
               mag = round_div(ma << 8, mb);
               clamp_word(neg ? -$signed(mag) : $signed(mag), r);
            end
         end
         OP_GT:      r.cmp = a > b;
         OP_LT:      r.cmp = a < b;
         OP_GE:      r.cmp = a >= b;
         OP_LE:      r.cmp = a <= b;
         OP_EQ:      r.cmp = a == b;
         OP_NE:      r.cmp = a != b;
         OP_MIN:     r.value = (a < b) ? a : b;
         OP_MAX:     r.value = (b < a) ? a : b;
         OP_INC:     clamp_word(wa + 1, r);
         OP_DEC:     clamp_word(wa - 1, r);
         OP_TOINT:   r.value = a >>> 8;
         default:    clamp_word(wa * 256, r);
      endcase
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      alu_result_t exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         expected_results.delete();
         error_count <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(compute_alu(op_type'(req_kind),
                                                   req_operand_a, req_operand_b));
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("result transfer with nothing expected");
               errs++;
            end else begin
               exp_r = expected_results.pop_front();
               if (rsp_result_value !== exp_r.value) begin
                  $error("result_value: expected %h, got %h", exp_r.value,
                         rsp_result_value);
                  errs++;
               end
               if (rsp_compare_flag !== exp_r.cmp) begin
                  $error("compare_flag: expected %b, got %b", exp_r.cmp,
                         rsp_compare_flag);
                  errs++;
               end
               if (rsp_overflow_flag !== exp_r.ovf) begin
                  $error("overflow_flag: expected %b, got %b", exp_r.ovf,
                         rsp_overflow_flag);
                  errs++;
               end
               if (rsp_divide_by_zero !== exp_r.dz) begin
                  $error("divide_by_zero: expected %b, got %b", exp_r.dz,
                         rsp_divide_by_zero);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
   end

endmodule

// ----- bench/fixed_point_q24_8_alu_tb.sv -----
module fixed_point_q24_8_alu_tb;
   import fqa_pkg::*;

   // The drain allowance after the last result is generous.
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1300;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [3:0]        req_kind = '0;
   logic [WORD_W-1:0] req_operand_a = '0;
   logic [WORD_W-1:0] req_operand_b = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [WORD_W-1:0] rsp_result_value;
   logic              rsp_compare_flag;
   logic              rsp_overflow_flag;
   logic              rsp_divide_by_zero;

   int error_count;
   int pending_count;
   int result_count;
   int idle_cycles = 0;
   int sent_items = 0;
   logic stimulus_done = 1'b0;

   always #1 clock = ~clock;

   fixed_point_q24_8_alu u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_compare_flag(rsp_compare_flag),
      .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   fixed_point_q24_8_alu_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_compare_flag(rsp_compare_flag),
      .rsp_overflow_flag(rsp_overflow_flag),
      .rsp_divide_by_zero(rsp_divide_by_zero),
      .error_count(error_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   // The receiver stalls in its own pattern: a mode is picked every so often,
   // switching between always ready, light stalls and heavy stalls.
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(10, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // The watchdog counts cycles in which no transfer happens on either
   // channel, and gives up when the count reaches the limit.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !reset) begin
         $display("watchdog expired with %0d results outstanding", pending_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Pick an operand that hits the interesting magnitudes often: the word
   // limits, zero, small values, values near the fixed-point one, and noise.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 2048)) - 1024);
         4: return 32'($urandom) >>> $urandom_range(0, 31);
         5: return {{24{1'b0}}, 8'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
         6: return 32'($urandom) & 32'h007f_ffff;
         7: return 32'($urandom) | 32'hff80_0000;
         default: return 32'($urandom);
      endcase
   endfunction

   // Present one item and hold it until the transfer happens.
   task automatic send_item(input op_type op, input logic [31:0] a,
                            input logic [31:0] b);
      req_valid <= 1'b1;
      req_kind <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] a;
      logic [31:0] b;
      int burst;
      op_type op;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: word limits on add and subtract, multiply and divide
      // rounding ties, division by zero of either sign, increment and
      // decrement at the limits, conversions at their saturation edges.
      send_item(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
      send_item(OP_SUB, 32'h8000_0000, 32'h0000_0001);
      send_item(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(OP_MUL, 32'h8000_0000, 32'h0000_0100);
      send_item(OP_MUL, 32'h0000_0001, 32'h0000_0080);
      send_item(OP_MUL, 32'hffff_ffff, 32'h0000_0080);
      send_item(OP_DIV, 32'h0000_0100, 32'h0000_0000);
      send_item(OP_DIV, 32'hffff_ff00, 32'h0000_0000);
      send_item(OP_DIV, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
      send_item(OP_DIV, 32'h0000_0001, 32'h0000_0200);
      send_item(OP_GT, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_GE, 32'h0000_0005, 32'h0000_0005);
      send_item(OP_LE, 32'h0000_0005, 32'h0000_0005);
      send_item(OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
      send_item(OP_NE, 32'hffff_ffff, 32'h0000_0000);
      send_item(OP_MIN, 32'h0000_0007, 32'h0000_0007);
      send_item(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_INC, 32'h7fff_ffff, 32'h0000_0000);
      send_item(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
      send_item(OP_TOINT, 32'hffff_ff01, 32'h0000_0000);
      send_item(OP_TOINT, 32'h7fff_ffff, 32'h0000_0000);
      send_item(OP_FROMINT, 32'h007f_ffff, 32'h0000_0000);
      send_item(OP_FROMINT, 32'hff80_0000, 32'h0000_0000);
      send_item(OP_FROMINT, 32'hff7f_ffff, 32'h0000_0000);

      // Random part: bursts of random length, some back to back with no
      // gap so the pipeline runs full, others separated by idle cycles.
      while (sent_items < RANDOM_ITEMS + 26) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            op = op_type'($urandom_range(0, 15));
            a = pick_operand();
            b = ($urandom_range(0, 19) == 0) ? 32'd0 : pick_operand();
            send_item(op, a, b);
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
      req_valid <= 1'b0;

      // Let the checker record the last transfer before looking at the count.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d items across all sixteen opcodes,",
               result_count, sent_items);
      $display("with word-limit operands, zero divisors and random stalls.");
      if (error_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- fixed_point_q24_8_alu.f -----
rtl/fqa_pkg.sv
rtl/fqa_simple_ops.sv
rtl/fqa_div_stage.sv
rtl/fixed_point_q24_8_alu.sv
bench/fixed_point_q24_8_alu_checker.sv
bench/fixed_point_q24_8_alu_tb.sv
